>>> hw/rtl/skyline_rect_packer_unit_assert.svh
// Assertion macros for the skyline rectangle packer.
// Taken in by the top level; no other dependencies.
`ifndef SKYLINE_RECT_PACKER_UNIT_ASSERT_SVH
`define SKYLINE_RECT_PACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication check.
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/srp_pkg.sv
// Shared types, constants and helpers of the skyline rectangle packer.
// No dependencies.
`default_nettype none

package srp_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int SZ_W          = 13;
    localparam int POS_W         = 12;
    localparam int ST_W          = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [SZ_W-1:0] ATLAS_RST = 13'd1024;
    localparam logic [SZ_W-1:0] ATLAS_MAX = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'd1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [SZ_W-1:0] x;
        logic [SZ_W-1:0] top;
        logic [SZ_W-1:0] width;
    } t_seg;

    typedef struct packed {
        logic clear;
        logic res_ok;
        logic res_nofit;
        logic res_full;
        logic scan_start;
        logic fit_step;
        logic build_start;
        logic copy_step;
        logic insert;
        logic flush;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic scan_last;
        logic found;
        logic full;
        logic best_zero;
        logic copy_last;
        logic next_ins;
        logic out_busy;
    } t_sts;

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v);
        clamp_size = (v > ATLAS_MAX) ? ATLAS_MAX : v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/srp_ctrl.sv
// Sequencer of the skyline packer: scan, decide, rebuild, deliver.
// Depends on srp_pkg.
`default_nettype none

module srp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_action,
    output logic               o_in_ready,
    input  wire srp_pkg::t_sts i_sts,
    output srp_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_DECIDE = 8'b0000_1000,
        ST_COPY   = 8'b0001_0000,
        ST_INS    = 8'b0010_0000,
        ST_FLUSH  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        o_cmd.clear  = 1'b1;
                        o_cmd.res_ok = 1'b1;
                        n_state      = ST_DONE;
                    end else if (i_sts.in_zero) begin
                        o_cmd.res_nofit = 1'b1;
                        n_state         = ST_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.fit_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_sts.found) begin
                    o_cmd.res_nofit = 1'b1;
                    n_state         = ST_DONE;
                end else if (i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.build_start = 1'b1;
                    n_state           = i_sts.best_zero ? ST_INS : ST_COPY;
                end
            end
            ST_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = ST_FLUSH;
                end else if (i_sts.next_ins) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_COPY;
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/srp_dpath.sv
// Datapath of the skyline packer: size registers, two skyline banks,
// fit scan, rebuild with trim and merge, output register.
// Depends on srp_pkg and srp_ram.
`default_nettype none

module srp_dpath #(
    parameter int MAX_NODES = srp_pkg::MAX_NODES_DEF,
    localparam int IDX_W = $clog2(MAX_NODES),
    localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire srp_pkg::t_cmd                  i_cmd,
    output srp_pkg::t_sts                       o_sts,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [srp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srp_pkg::SZ_W-1:0]       i_cfg_data,
    input  wire logic [srp_pkg::SZ_W-1:0]       i_rect_width,
    input  wire logic [srp_pkg::SZ_W-1:0]       i_rect_height,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic      [srp_pkg::POS_W-1:0]      o_pos_x,
    output logic      [srp_pkg::POS_W-1:0]      o_pos_y,
    output logic      [srp_pkg::ST_W-1:0]       o_status,
    output logic      [CNT_W-1:0]               o_count
);

    localparam int SZ_W  = srp_pkg::SZ_W;
    localparam int POS_W = srp_pkg::POS_W;
    localparam int SEG_W = $bits(srp_pkg::t_seg);

    // control state
    logic [SZ_W-1:0]  r_aw, r_ah;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_bank, n_bank;
    logic             r_out_valid, n_out_valid;
    logic             r_found, n_found;
    logic             r_pend_v, n_pend_v;
    logic             r_trim, n_trim;
    logic             r_first, n_first;

    // working payload
    logic [SZ_W-1:0]        r_w, n_w, r_h, n_h;
    logic [CNT_W-1:0]       r_ptr, n_ptr, r_s, n_s, r_best, n_best, r_wptr, n_wptr;
    logic [SZ_W-1:0]        r_y, n_y, r_sx, n_sx, r_sw, n_sw;
    logic signed [SZ_W+1:0] r_left, n_left;
    logic [SZ_W-1:0]        r_best_top, n_best_top, r_best_w, n_best_w;
    logic [SZ_W-1:0]        r_best_y, n_best_y, r_best_x, n_best_x;
    srp_pkg::t_seg          r_pend, n_pend;
    logic [POS_W-1:0]       r_res_x, n_res_x, r_res_y, n_res_y;
    logic [POS_W-1:0]       r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [srp_pkg::ST_W-1:0] r_res_st, n_res_st, r_status, n_status;

    // bank access
    logic             wr_en, wr_other;
    logic [IDX_W-1:0] wr_addr;
    srp_pkg::t_seg    wr_seg;
    logic [SEG_W-1:0] rd0, rd1;
    srp_pkg::t_seg    d;

    // scan and rebuild terms
    logic [SZ_W-1:0]        y0, ynew, sw_cur, ctop;
    logic signed [SZ_W+1:0] left0, leftn, nw;
    logic                   xfail, hfail, fit_now, stop, better;
    logic [CNT_W-1:0]       ptr1, s1;
    logic [SZ_W:0]          xsum, hsum, edge_sum;
    logic [SZ_W-1:0]        edge_x;
    logic                   emit_v;
    srp_pkg::t_seg          emit_seg;

    srp_ram #(.WIDTH(SEG_W), .DEPTH(MAX_NODES)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && ((wr_other ^ r_bank) == 1'b0)),
        .i_waddr (wr_addr),
        .i_wdata (wr_seg),
        .i_raddr (n_ptr[IDX_W-1:0]),
        .o_rdata (rd0)
    );

    srp_ram #(.WIDTH(SEG_W), .DEPTH(MAX_NODES)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && ((wr_other ^ r_bank) == 1'b1)),
        .i_waddr (wr_addr),
        .i_wdata (wr_seg),
        .i_raddr (n_ptr[IDX_W-1:0]),
        .o_rdata (rd1)
    );

    assign d = srp_pkg::t_seg'(r_bank ? rd1 : rd0);

    // fit step terms for the segment under the cursor
    always_comb begin
        y0       = r_first ? d.top : r_y;
        ynew     = (d.top > y0) ? d.top : y0;
        left0    = r_first ? $signed({2'b00, r_w}) : r_left;
        leftn    = left0 - $signed({2'b00, d.width});
        xsum     = {1'b0, d.x} + {1'b0, r_w};
        xfail    = r_first && (xsum > {1'b0, r_aw});
        hsum     = {1'b0, ynew} + {1'b0, r_h};
        hfail    = hsum > {1'b0, r_ah};
        fit_now  = !xfail && !hfail && (leftn[SZ_W+1] || (leftn == '0));
        ptr1     = r_ptr + 1'b1;
        s1       = r_s + 1'b1;
        stop     = xfail || hfail || fit_now || (ptr1 >= r_count);
        sw_cur   = r_first ? d.width : r_sw;
        ctop     = hsum[SZ_W-1:0];
        better   = fit_now && (!r_found || (ctop < r_best_top) ||
                   ((ctop == r_best_top) && (sw_cur < r_best_w)));
        edge_sum = {1'b0, r_best_x} + {1'b0, r_w};
        edge_x   = edge_sum[SZ_W-1:0];
        nw       = $signed({2'b00, d.x}) + $signed({2'b00, d.width})
                   - $signed({2'b00, edge_x});
    end

    always_comb begin
        n_count = r_count;  n_bank = r_bank;  n_out_valid = r_out_valid;
        n_found = r_found;  n_pend_v = r_pend_v;  n_trim = r_trim;
        n_first = r_first;  n_w = r_w;  n_h = r_h;  n_ptr = r_ptr;  n_s = r_s;
        n_best = r_best;  n_wptr = r_wptr;  n_y = r_y;  n_sx = r_sx;
        n_sw = r_sw;  n_left = r_left;  n_best_top = r_best_top;
        n_best_w = r_best_w;  n_best_y = r_best_y;  n_best_x = r_best_x;
        n_pend = r_pend;  n_res_x = r_res_x;  n_res_y = r_res_y;
        n_res_st = r_res_st;  n_pos_x = r_pos_x;  n_pos_y = r_pos_y;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_other = 1'b1;
        wr_addr  = r_wptr[IDX_W-1:0];
        wr_seg   = r_pend;
        emit_v   = 1'b0;
        emit_seg = d;

        if (i_cmd.clear) begin
            // one full-width segment in the live bank
            wr_en    = 1'b1;
            wr_other = 1'b0;
            wr_addr  = '0;
            wr_seg   = '{x: '0, top: '0, width: r_aw};
            n_count  = CNT_W'(1);
        end
        if (i_cmd.res_ok) begin
            n_res_x = '0;  n_res_y = '0;  n_res_st = srp_pkg::ST_OK;
        end
        if (i_cmd.res_nofit) begin
            n_res_x = '0;  n_res_y = '0;  n_res_st = srp_pkg::ST_NOFIT;
        end
        if (i_cmd.res_full) begin
            n_res_x = '0;  n_res_y = '0;  n_res_st = srp_pkg::ST_FULL;
        end
        if (i_cmd.scan_start) begin
            n_w = i_rect_width;  n_h = i_rect_height;
            n_ptr = '0;  n_s = '0;  n_first = 1'b1;  n_found = 1'b0;
        end
        if (i_cmd.fit_step) begin
            if (better) begin
                n_found    = 1'b1;
                n_best     = r_s;
                n_best_top = ctop;
                n_best_w   = sw_cur;
                n_best_y   = ynew;
                n_best_x   = r_first ? d.x : r_sx;
            end
            if (stop) begin
                n_s = s1;  n_ptr = s1;  n_first = 1'b1;
            end else begin
                n_ptr = ptr1;  n_first = 1'b0;  n_y = ynew;  n_left = leftn;
                if (r_first) begin
                    n_sx = d.x;  n_sw = d.width;
                end
            end
        end
        if (i_cmd.build_start) begin
            n_ptr = '0;  n_wptr = '0;  n_pend_v = 1'b0;  n_trim = 1'b0;
            n_res_x  = r_best_x[POS_W-1:0];
            n_res_y  = r_best_y[POS_W-1:0];
            n_res_st = srp_pkg::ST_OK;
        end
        if (i_cmd.copy_step) begin
            n_ptr = ptr1;
            if (!r_trim) begin
                emit_v = 1'b1;
            end else if (d.x >= edge_x) begin
                emit_v = 1'b1;
                n_trim = 1'b0;
            end else if (!nw[SZ_W+1] && (nw != '0)) begin
                // partly covered: keep the part right of the new segment
                emit_v   = 1'b1;
                emit_seg = '{x: edge_x, top: d.top, width: nw[SZ_W-1:0]};
                n_trim   = 1'b0;
            end
        end
        if (i_cmd.insert) begin
            emit_v   = 1'b1;
            emit_seg = '{x: r_best_x, top: r_best_top, width: r_w};
            n_trim   = 1'b1;
        end
        // merge equal tops as segments stream into the spare bank
        if (emit_v) begin
            if (!r_pend_v) begin
                n_pend   = emit_seg;
                n_pend_v = 1'b1;
            end else if (emit_seg.top == r_pend.top) begin
                n_pend.width = r_pend.width + emit_seg.width;
            end else begin
                wr_en  = 1'b1;
                n_wptr = r_wptr + 1'b1;
                n_pend = emit_seg;
            end
        end
        if (i_cmd.flush) begin
            wr_en   = 1'b1;
            n_count = r_wptr + 1'b1;
            n_bank  = ~r_bank;
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_pos_x = r_res_x;  n_pos_y = r_res_y;  n_status = r_res_st;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw        <= srp_pkg::ATLAS_RST;
            r_ah        <= srp_pkg::ATLAS_RST;
            r_count     <= CNT_W'(1);
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_trim      <= 1'b0;
            r_first     <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    srp_pkg::REG_ATLAS_WIDTH:  r_aw <= srp_pkg::clamp_size(i_cfg_data);
                    srp_pkg::REG_ATLAS_HEIGHT: r_ah <= srp_pkg::clamp_size(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            r_count     <= n_count;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_pend_v    <= n_pend_v;
            r_trim      <= n_trim;
            r_first     <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;  r_h <= n_h;  r_ptr <= n_ptr;  r_s <= n_s;  r_best <= n_best;
        r_wptr <= n_wptr;  r_y <= n_y;  r_sx <= n_sx;  r_sw <= n_sw;
        r_left <= n_left;  r_best_top <= n_best_top;  r_best_w <= n_best_w;
        r_best_y <= n_best_y;  r_best_x <= n_best_x;  r_pend <= n_pend;
        r_res_x <= n_res_x;  r_res_y <= n_res_y;  r_res_st <= n_res_st;
        r_pos_x <= n_pos_x;  r_pos_y <= n_pos_y;  r_status <= n_status;
    end

    always_comb begin
        o_sts.in_zero   = (i_rect_width == '0) || (i_rect_height == '0);
        o_sts.scan_last = stop && (s1 >= r_count);
        o_sts.found     = r_found;
        o_sts.full      = r_count >= CNT_W'(MAX_NODES);
        o_sts.best_zero = (r_best == '0);
        o_sts.copy_last = (ptr1 == r_count);
        o_sts.next_ins  = !r_trim && (ptr1 == r_best);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_status    = r_status;
    assign o_count     = r_count;

endmodule

`default_nettype wire

>>> hw/rtl/skyline_rect_packer_unit.sv
// Skyline packer, top level: lowest fit wins, narrower start segment on a tie.
// Depends on srp_pkg, srp_ctrl, srp_dpath and the assertion header.
// Request channel (i_in_valid / o_in_ready): action, rect_width, rect_height.
//  Action 1 clears the skyline to one atlas-wide segment; action 0 places.
// Result channel (o_out_valid / i_out_ready): pos_x, pos_y and status
//  (placed or cleared, no fit, skyline full), one per request.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): atlas
//  width (index 0) or height (index 1); values above 4096 clamp. Write only
//  while idle; the skyline itself changes at the next clear.
// Sequence: a place request with N segments walks every start segment through
//  the span it covers, one segment read per cycle; then it decides, streams
//  the rebuilt skyline into the spare bank and loads the result. A clear or
//  a zero-sized request goes straight to the done state and loads its
//  result register once the result side is free.
// Throughput: one request at a time. The result register frees the request
//  side: the next request is taken while a result waits, then holds in its
//  final state until the receiver takes the earlier result.
// Reset: one cycle after reset writes the single 1024-wide segment, then the
//  block is ready.
`default_nettype none
`include "skyline_rect_packer_unit_assert.svh"

module skyline_rect_packer_unit #(
    parameter int MAX_NODES = srp_pkg::MAX_NODES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic [srp_pkg::SZ_W-1:0]      i_rect_width,
    input  wire logic [srp_pkg::SZ_W-1:0]      i_rect_height,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [srp_pkg::POS_W-1:0]     o_pos_x,
    output logic      [srp_pkg::POS_W-1:0]     o_pos_y,
    output logic      [srp_pkg::ST_W-1:0]      o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [srp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [srp_pkg::SZ_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);

    srp_pkg::t_cmd    cmd;
    srp_pkg::t_sts    sts;
    logic [CNT_W-1:0] seg_count;

    // sequencer: owns the request handshake and drives the datapath
    srp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // skyline banks, scan, rebuild and the result register
    srp_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_status      (o_status),
        .o_count       (seg_count)
    );

    // one request in flight: ready drops right after a request is taken
    `SRP_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // the segment count stays within the table
    `SRP_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, (seg_count != '0) && (seg_count <= CNT_W'(MAX_NODES)))
    // a placement refused for a full skyline reports no position
    `SRP_ASSERT_IMP(a_full_no_pos, i_clk, i_rst_n, o_out_valid && (o_status == srp_pkg::ST_FULL), (o_pos_x == '0) && (o_pos_y == '0))

endmodule

`default_nettype wire
